// File: rtl/core/pte_pkg.sv
package pte_pkg;

  localparam int PTE_MAX_PIECES   = 64;
  localparam int PTE_MAX_READ_RUN = 64;
  localparam int PTE_OFFSET_BITS  = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_POS  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CHECK    = 9'b000000010,
    S_FETCH    = 9'b000000100,
    S_SPLIT    = 9'b000001000,
    S_TAIL     = 9'b000010000,
    S_COMMIT   = 9'b000100000,
    S_RD_PIECE = 9'b001000000,
    S_RD_BYTE  = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

endpackage

// File: rtl/core/piece_table_edit_engine_unit.sv
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready  | in_tuser command, in_tdata edit/read operands
// out_    | out | out_tvalid / out_tready| out_tuser status+byte_valid, out_tdata, out_tlast
//
// an edit walks the stored pieces in order: every piece is read from the live bank
// (registered read) and up to three pieces are written to the spare bank, one per
// cycle; a good edit swaps the banks, a failed one drops the copy
// a read fetches and checks each piece walked, then sends its bytes as beats
// reset empties the table at once (count and length cleared, no clearing pass)
// a stalled output holds the walk; the next beat is taken once the current one is done
module piece_table_edit_engine_unit
  import pte_pkg::*;
#(
  parameter int MAX_PIECES   = PTE_MAX_PIECES,
  parameter int MAX_READ_RUN = PTE_MAX_READ_RUN,
  parameter int OFFSET_BITS  = PTE_OFFSET_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // command
  // position[31:0], byte_count[63:32], source_id[71:64], source_start[103:72],
  // mark_changed[104], zero pad
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [2:0]   out_tuser,  // status[1:0], byte_valid[2]
  // byte_source[7:0], byte_address[39:8], byte_changed[40], total_length[72:41], zero pad
  output logic [79:0]  out_tdata,
  output logic         out_tlast
);

  localparam int CW   = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;
  localparam int AW   = $clog2(MAX_PIECES);
  localparam int NCW  = $clog2(MAX_PIECES + 1);
  localparam int NW   = $clog2(MAX_READ_RUN + 1);
  localparam int DW   = OFFSET_BITS + 8 + 32 + 1;

  typedef logic [CW-1:0] off_t;
  typedef struct packed {
    logic       vld;
    off_t       len;
    logic [7:0] src;
    logic [31:0] start;
    logic       chg;
  } slot_t;

  localparam off_t LEN_LIMIT = off_t'({OFFSET_BITS{1'b1}});
  localparam off_t RUN_LIMIT = off_t'(MAX_READ_RUN);

  // control and latched command
  state_t            state_r, state_nxt;
  logic [1:0]        cmd_r;
  off_t              pos_r, cnt_r, end_r, end_nxt;
  logic [7:0]        nsrc_r;
  logic [31:0]       nstart_r;
  logic              nchg_r;
  logic [NCW-1:0]    count_r, count_nxt;
  logic [OFFSET_BITS-1:0] blen_r, blen_nxt;
  logic              bank_r, bank_nxt;
  logic [NCW-1:0]    idx_r, idx_nxt;
  logic [NCW-1:0]    wcnt_r, wcnt_nxt;
  off_t              at_r, at_nxt;
  logic              added_r, added_nxt;
  logic              ovf_r, ovf_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [NW-1:0]     k_r, k_nxt;
  off_t              j_r, j_nxt;
  off_t              to_r, to_nxt;

  // output register
  logic              out_valid_r;
  logic [2:0]        out_user_r, out_user_nxt;
  logic [79:0]       out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load;
  logic              out_free;

  // memories
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DW-1:0]     rd_data0, rd_data1, rd_q;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DW-1:0]     wr_data;

  // fields of the piece just read
  off_t              plen;
  logic [7:0]        psrc;
  logic [31:0]       pstart;
  logic              pchg;
  off_t              aplen;
  off_t              blen_w;
  off_t              in_pos, in_cnt;
  off_t              avail;
  off_t              nrun;
  slot_t             slots [3];
  slot_t             cur_slot;
  logic              piece_adds;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  assign blen_w = off_t'(blen_r);
  assign in_pos = off_t'(in_tdata[31:0]);
  assign in_cnt = off_t'(in_tdata[63:32]);

  pte_ram #(.DEPTH(MAX_PIECES), .WIDTH(DW)) u_bank0 (
    .clk     (clk),
    .wr_en   (wr_en && bank_r),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en && !bank_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data0)
  );

  pte_ram #(.DEPTH(MAX_PIECES), .WIDTH(DW)) u_bank1 (
    .clk     (clk),
    .wr_en   (wr_en && !bank_r),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en && bank_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data1)
  );

  // live bank is bank_r, edits copy into the other one
  assign rd_q   = bank_r ? rd_data1 : rd_data0;
  assign plen   = off_t'(rd_q[DW-1 -: OFFSET_BITS]);
  assign psrc   = rd_q[40:33];
  assign pstart = rd_q[32:1];
  assign pchg   = rd_q[0];
  assign aplen  = at_r + plen;

  assign avail  = blen_w - pos_r;

  // split of the current piece into up to three output pieces
  always_comb begin
    off_t head;
    off_t skip;
    head       = pos_r - at_r;
    skip       = end_r - at_r;
    piece_adds = 1'b0;
    for (int s = 0; s < 3; s++) begin
      slots[s] = '0;
    end
    if (cmd_r == CMD_INSERT) begin
      if (!added_r && pos_r == at_r) begin
        slots[0]   = '{1'b1, cnt_r, nsrc_r, nstart_r, nchg_r};
        slots[1]   = '{1'b1, plen, psrc, pstart, pchg};
        piece_adds = 1'b1;
      end else if (!added_r && pos_r > at_r && pos_r < aplen) begin
        slots[0]   = '{1'b1, head, psrc, pstart, pchg};
        slots[1]   = '{1'b1, cnt_r, nsrc_r, nstart_r, nchg_r};
        slots[2]   = '{1'b1, plen - head, psrc, pstart + head[31:0], pchg};
        piece_adds = 1'b1;
      end else begin
        slots[0] = '{1'b1, plen, psrc, pstart, pchg};
      end
    end else begin
      if (aplen <= pos_r || at_r >= end_r) begin
        slots[0] = '{1'b1, plen, psrc, pstart, pchg};
      end else begin
        // piece overlaps the cut: keep what lies before and after it
        slots[0] = '{(at_r < pos_r), head, psrc, pstart, pchg};
        slots[1] = '{(aplen > end_r), plen - skip, psrc, pstart + skip[31:0], pchg};
      end
    end
    case (slot_r)
      2'd0:    cur_slot = slots[0];
      2'd1:    cur_slot = slots[1];
      2'd2:    cur_slot = slots[2];
      default: cur_slot = '0;
    endcase
  end

  // read run length of the incoming beat: bytes that exist, capped by the request
  // and the run limit
  always_comb begin
    nrun = blen_w - in_pos;
    if (in_cnt < nrun) begin
      nrun = in_cnt;
    end
    if (RUN_LIMIT < nrun) begin
      nrun = RUN_LIMIT;
    end
  end

  always_comb begin
    off_t to_w;
    off_t jend;
    state_nxt    = state_r;
    end_nxt      = end_r;
    count_nxt    = count_r;
    blen_nxt     = blen_r;
    bank_nxt     = bank_r;
    idx_nxt      = idx_r;
    wcnt_nxt     = wcnt_r;
    at_nxt       = at_r;
    added_nxt    = added_r;
    ovf_nxt      = ovf_r;
    slot_nxt     = slot_r;
    status_nxt   = status_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    to_nxt       = to_r;
    out_load     = 1'b0;
    out_user_nxt = out_user_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    rd_en        = 1'b0;
    rd_addr      = idx_r[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = wcnt_r[AW-1:0];
    wr_data      = {cur_slot.len[OFFSET_BITS-1:0], cur_slot.src, cur_slot.start,
                    cur_slot.chg};
    to_w         = ((end_r < aplen) ? end_r : aplen) - at_r;
    jend         = j_r + off_t'(1);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CHECK;
          // read end is known only after the check, edits take it now
          end_nxt   = in_pos + in_cnt;
          idx_nxt   = '0;
          wcnt_nxt  = '0;
          at_nxt    = '0;
          added_nxt = 1'b0;
          ovf_nxt   = 1'b0;
          slot_nxt  = '0;
          k_nxt     = '0;
          n_nxt     = nrun[NW-1:0];
        end
      end

      S_CHECK: begin
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
        case (cmd_r)
          CMD_INSERT: begin
            if (pos_r > blen_w) begin
              status_nxt = ST_BAD_POS;
            end else if (cnt_r > LEN_LIMIT - blen_w) begin
              status_nxt = ST_TOO_LONG;
            end else if (cnt_r != '0) begin
              state_nxt = (count_r == '0) ? S_TAIL : S_FETCH;
            end
          end
          CMD_REMOVE: begin
            if (pos_r >= blen_w) begin
              status_nxt = ST_BAD_POS;
            end else if (cnt_r > avail) begin
              status_nxt = ST_TOO_LONG;
            end else if (cnt_r != '0) begin
              state_nxt = S_FETCH;
            end
          end
          CMD_READ: begin
            if (pos_r > blen_w) begin
              status_nxt = ST_BAD_POS;
            end else if (n_r != '0) begin
              end_nxt   = pos_r + off_t'(n_r);
              state_nxt = S_FETCH;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end

      S_FETCH: begin
        rd_en     = 1'b1;
        slot_nxt  = '0;
        state_nxt = (cmd_r == CMD_READ) ? S_RD_PIECE : S_SPLIT;
      end

      S_SPLIT: begin
        if (cur_slot.vld) begin
          if (wcnt_r == NCW'(MAX_PIECES)) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en    = 1'b1;
            wcnt_nxt = wcnt_r + NCW'(1);
          end
        end
        if (slot_r == 2'd2) begin
          at_nxt    = aplen;
          added_nxt = added_r | piece_adds;
          idx_nxt   = idx_r + NCW'(1);
          if (idx_r + NCW'(1) == count_r) begin
            state_nxt = (cmd_r == CMD_INSERT && !(added_r | piece_adds)) ?
                        S_TAIL : S_COMMIT;
          end else begin
            state_nxt = S_FETCH;
          end
        end else begin
          slot_nxt = slot_r + 2'd1;
        end
      end

      S_TAIL: begin
        // insert at the very end
        wr_data = {cnt_r[OFFSET_BITS-1:0], nsrc_r, nstart_r, nchg_r};
        if (wcnt_r == NCW'(MAX_PIECES)) begin
          ovf_nxt = 1'b1;
        end else begin
          wr_en    = 1'b1;
          wcnt_nxt = wcnt_r + NCW'(1);
        end
        state_nxt = S_COMMIT;
      end

      S_COMMIT: begin
        state_nxt = S_RESP;
        if (ovf_r) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          bank_nxt   = !bank_r;
          count_nxt  = wcnt_r;
          if (cmd_r == CMD_INSERT) begin
            blen_nxt = OFFSET_BITS'(blen_w + cnt_r);
          end else begin
            blen_nxt = OFFSET_BITS'(blen_w - cnt_r);
          end
        end
      end

      S_RD_PIECE: begin
        if (aplen > pos_r) begin
          j_nxt     = (pos_r > at_r) ? (pos_r - at_r) : '0;
          to_nxt    = to_w;
          state_nxt = S_RD_BYTE;
        end else begin
          at_nxt    = aplen;
          idx_nxt   = idx_r + NCW'(1);
          state_nxt = S_FETCH;
        end
      end

      S_RD_BYTE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_user_nxt = {1'b1, ST_OK};
          out_data_nxt = {7'd0, blen_w[31:0], pchg, pstart + j_r[31:0], psrc};
          out_last_nxt = (k_r + NW'(1) == n_r);
          k_nxt        = k_r + NW'(1);
          j_nxt        = jend;
          if (k_r + NW'(1) == n_r) begin
            state_nxt = S_IDLE;
          end else if (jend == to_r) begin
            at_nxt    = aplen;
            idx_nxt   = idx_r + NCW'(1);
            state_nxt = S_FETCH;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_user_nxt = {1'b0, status_r};
          out_data_nxt = {7'd0, blen_w[31:0], 41'd0};
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      blen_r      <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      blen_r      <= blen_nxt;
      bank_r      <= bank_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk registers and payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      cmd_r    <= in_tuser;
      pos_r    <= in_pos;
      cnt_r    <= in_cnt;
      nsrc_r   <= in_tdata[71:64];
      nstart_r <= in_tdata[103:72];
      nchg_r   <= in_tdata[104];
    end
    end_r      <= end_nxt;
    idx_r      <= idx_nxt;
    wcnt_r     <= wcnt_nxt;
    at_r       <= at_nxt;
    added_r    <= added_nxt;
    ovf_r      <= ovf_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    to_r       <= to_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// File: rtl/core/pte_ram.sv
module pte_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 73
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/pte_checker.sv
module pte_checker
  import pte_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [2:0]   out_tuser,
  input logic [79:0]  out_tdata,
  input logic         out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one command at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // an error status is a lone beat without a byte
  a_err_lone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != ST_OK |-> out_tlast && !out_tuser[2])
    else $error("error status on a byte beat");

  // a beat without a byte ends its command
  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tlast)
    else $error("status beat not last");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

endmodule

bind piece_table_edit_engine_unit pte_checker u_pte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: tb/piece_table_checker.sv
module piece_table_checker
  import pte_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [1:0]   in_tuser,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [2:0]   out_tuser,
  input  logic [79:0]  out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic        valid;
    logic [7:0]  src;
    logic [31:0] addr;
    logic        chg;
    logic [31:0] total;
    logic        last;
  } beat_t;

  typedef struct {
    logic [63:0] len;
    logic [7:0]  src;
    logic [31:0] start;
    logic        chg;
  } piece_t;

  piece_t table_q[$];
  logic [63:0] buf_len;
  beat_t expected_beats[$];

  assign pending_count = expected_beats.size();

  function automatic beat_t mk(logic [1:0] st, logic v, logic [7:0] s, logic [31:0] a,
                               logic c, logic l);
    beat_t b;
    b.status = st; b.valid = v; b.src = s; b.addr = a; b.chg = c;
    b.total = buf_len[31:0]; b.last = l;
    return b;
  endfunction

  // keeps nonzero pieces, flags overflow of the table
  function automatic void add_piece(ref piece_t nq[$], ref bit ovf, input logic [63:0] len,
                                    input logic [7:0] s, input logic [31:0] st,
                                    input logic c);
    piece_t p;
    if (len == 0) return;
    if (nq.size() >= PTE_MAX_PIECES) begin
      ovf = 1;
      return;
    end
    p.len = len; p.src = s; p.start = st; p.chg = c;
    nq.push_back(p);
  endfunction

  function automatic logic [1:0] apply_insert(logic [63:0] pos, logic [63:0] cnt,
                                              logic [7:0] s, logic [31:0] st, logic c);
    piece_t nq[$];
    bit ovf, added;
    logic [63:0] at, head;
    ovf = 0; added = 0; at = 0;
    if (pos > buf_len) return ST_BAD_POS;
    if (cnt > 64'hFFFF_FFFF - buf_len) return ST_TOO_LONG;
    if (cnt == 0) return ST_OK;
    foreach (table_q[i]) begin
      if (!added && pos == at) begin
        add_piece(nq, ovf, cnt, s, st, c);
        add_piece(nq, ovf, table_q[i].len, table_q[i].src, table_q[i].start, table_q[i].chg);
        added = 1;
      end else if (!added && pos > at && pos < at + table_q[i].len) begin
        head = pos - at;
        add_piece(nq, ovf, head, table_q[i].src, table_q[i].start, table_q[i].chg);
        add_piece(nq, ovf, cnt, s, st, c);
        add_piece(nq, ovf, table_q[i].len - head, table_q[i].src,
                  table_q[i].start + head[31:0], table_q[i].chg);
        added = 1;
      end else begin
        add_piece(nq, ovf, table_q[i].len, table_q[i].src, table_q[i].start, table_q[i].chg);
      end
      at += table_q[i].len;
    end
    if (!added) add_piece(nq, ovf, cnt, s, st, c);
    if (ovf) return ST_FULL;
    table_q = nq;
    buf_len += cnt;
    return ST_OK;
  endfunction

  function automatic logic [1:0] apply_remove(logic [63:0] pos, logic [63:0] cnt);
    piece_t nq[$];
    bit ovf;
    logic [63:0] at, stop, skip, len;
    ovf = 0; at = 0;
    if (pos >= buf_len) return ST_BAD_POS;
    if (cnt > buf_len - pos) return ST_TOO_LONG;
    if (cnt == 0) return ST_OK;
    stop = pos + cnt;
    foreach (table_q[i]) begin
      len = table_q[i].len;
      if (at + len <= pos || at >= stop) begin
        add_piece(nq, ovf, len, table_q[i].src, table_q[i].start, table_q[i].chg);
      end else begin
        if (at < pos)
          add_piece(nq, ovf, pos - at, table_q[i].src, table_q[i].start, table_q[i].chg);
        if (at + len > stop) begin
          skip = stop > at ? stop - at : 0;
          add_piece(nq, ovf, len - skip, table_q[i].src, table_q[i].start + skip[31:0],
                    table_q[i].chg);
        end
      end
      at += len;
    end
    if (ovf) return ST_FULL;
    table_q = nq;
    buf_len -= cnt;
    return ST_OK;
  endfunction

  function automatic void translate_read(logic [63:0] pos, logic [63:0] cnt);
    logic [63:0] n, at, stop, from, upto, len;
    int k;
    at = 0; k = 0;
    if (pos > buf_len) begin
      expected_beats.push_back(mk(ST_BAD_POS, 0, 0, 0, 0, 1));
      return;
    end
    n = buf_len - pos;
    if (cnt < n) n = cnt;
    if (n > PTE_MAX_READ_RUN) n = PTE_MAX_READ_RUN;
    if (n == 0) begin
      expected_beats.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
      return;
    end
    stop = pos + n;
    foreach (table_q[i]) begin
      if (at >= stop) break;
      len = table_q[i].len;
      if (at + len > pos) begin
        from = pos > at ? pos - at : 0;
        upto = (stop < at + len ? stop : at + len) - at;
        for (logic [63:0] j = from; j < upto; j++) begin
          k++;
          expected_beats.push_back(mk(ST_OK, 1, table_q[i].src, table_q[i].start + j[31:0],
                                      table_q[i].chg, k == n));
        end
      end
      at += len;
    end
  endfunction

  always @(posedge clk) begin
    logic [1:0] st;
    beat_t got, exp_b;
    if (!rst_n) begin
      table_q.delete();
      expected_beats.delete();
      buf_len = 0;
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tuser[1:0]; got.valid = out_tuser[2];
        got.src = out_tdata[7:0]; got.addr = out_tdata[39:8]; got.chg = out_tdata[40];
        got.total = out_tdata[72:41]; got.last = out_tlast;
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat %h", got);
          fail_count++;
        end else begin
          exp_b = expected_beats.pop_front();
          if (got.status !== exp_b.status) begin
            $error("status exp %0d got %0d", exp_b.status, got.status); fail_count++;
          end
          if (got.valid !== exp_b.valid) begin
            $error("byte_valid exp %0d got %0d", exp_b.valid, got.valid); fail_count++;
          end
          if (got.src !== exp_b.src) begin
            $error("byte_source exp %0h got %0h", exp_b.src, got.src); fail_count++;
          end
          if (got.addr !== exp_b.addr) begin
            $error("byte_address exp %0h got %0h", exp_b.addr, got.addr); fail_count++;
          end
          if (got.chg !== exp_b.chg) begin
            $error("byte_changed exp %0d got %0d", exp_b.chg, got.chg); fail_count++;
          end
          if (got.total !== exp_b.total) begin
            $error("total_length exp %0d got %0d", exp_b.total, got.total); fail_count++;
          end
          if (got.last !== exp_b.last) begin
            $error("last exp %0d got %0d", exp_b.last, got.last); fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          CMD_INSERT: begin
            st = apply_insert({32'd0, in_tdata[31:0]}, {32'd0, in_tdata[63:32]},
                              in_tdata[71:64], in_tdata[103:72], in_tdata[104]);
            expected_beats.push_back(mk(st, 0, 0, 0, 0, 1));
          end
          CMD_REMOVE: begin
            st = apply_remove({32'd0, in_tdata[31:0]}, {32'd0, in_tdata[63:32]});
            expected_beats.push_back(mk(st, 0, 0, 0, 0, 1));
          end
          CMD_READ: translate_read({32'd0, in_tdata[31:0]}, {32'd0, in_tdata[63:32]});
          default: expected_beats.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
        endcase
      end
    end
  end
endmodule

// File: tb/tb_piece_table_edit_engine_unit.sv
module tb_piece_table_edit_engine_unit;
  import pte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;   // command
  // position, byte_count, source_id, source_start, mark_changed, zero pad
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [2:0]   out_tuser;       // status, byte_valid
  // byte_source, byte_address, byte_changed, total_length, zero pad
  logic [79:0]  out_tdata;
  logic         out_tlast;
  int           fail_count, pending_count;
  int           idle_pct = 10;   // idling chance in percent, zero for a quiet stretch
  int           quiet_cycles = 0;
  logic [31:0]  model_len = 0;   // rough buffer length to steer positions

  always #2 clk = ~clk;

  piece_table_edit_engine_unit dut (.*);

  piece_table_checker chk (.*);

  // receiver stalls at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one command beat, with random gaps before it; valid stays up after the
  // accepting edge until the next beat or an idle gap replaces it
  task automatic send_cmd(logic [1:0] cmd, logic [31:0] pos, logic [31:0] cnt,
                          logic [7:0] src, logic [31:0] start, logic chg);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, chg, start, src, cnt, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // track length roughly for stimulus shaping only
    if (cmd == CMD_INSERT && pos <= model_len && cnt <= 32'd4096) model_len += cnt;
    if (cmd == CMD_REMOVE && pos < model_len && cnt <= model_len - pos) model_len -= cnt;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    logic [1:0]  cmd;
    logic [31:0] pos, cnt;
    int r;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: corners, starting from an empty table
    send_cmd(CMD_READ, 0, 5, 0, 0, 0);               // empty read
    send_cmd(CMD_REMOVE, 0, 0, 0, 0, 0);             // remove on empty, bad position
    send_cmd(CMD_INSERT, 1, 4, 1, 0, 0);             // insert past end
    send_cmd(CMD_INSERT, 0, 0, 1, 0, 0);             // zero-length insert
    send_cmd(CMD_INSERT, 0, 10, 8'hFF, 32'hFFFF_FFFC, 1); // address wraps on read
    send_cmd(CMD_INSERT, 10, 6, 8'h00, 32'h0, 0);    // at end
    send_cmd(CMD_INSERT, 0, 3, 8'h55, 32'h100, 1);   // at boundary
    send_cmd(CMD_INSERT, 5, 2, 8'hAA, 32'h200, 0);   // split inside
    send_cmd(CMD_READ, 0, 32'hFFFF_FFFF, 0, 0, 0);   // shortened read
    send_cmd(CMD_READ, 21, 4, 0, 0, 0);              // read at end, no bytes
    send_cmd(CMD_READ, 22, 4, 0, 0, 0);              // read past end
    send_cmd(CMD_INSERT, 0, 32'hFFFF_FFFF, 1, 0, 0); // length overflow
    send_cmd(CMD_REMOVE, 21, 0, 0, 0, 0);            // remove start out of range
    send_cmd(CMD_REMOVE, 4, 30, 0, 0, 0);            // remove too long
    send_cmd(CMD_REMOVE, 4, 0, 0, 0, 0);             // zero remove
    send_cmd(CMD_REMOVE, 2, 9, 0, 0, 0);             // crosses pieces
    send_cmd(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1); // unknown
    send_cmd(CMD_READ, 0, 64, 0, 0, 0);
    // pause until everything has come back
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    // grow the table with forty one-byte inserts at position 1
    for (int i = 0; i < 40; i++) send_cmd(CMD_INSERT, 1, 1, i[7:0], i * 16, i[0]);
    send_cmd(CMD_REMOVE, 3, 1, 0, 0, 0);             // one-byte remove inside the grown table
    send_cmd(CMD_READ, 0, 64, 0, 0, 0);
    drain();
    // clear back to small length
    send_cmd(CMD_REMOVE, 0, model_len, 0, 0, 0);
    drain();

    for (int n = 0; n < 210; n++) begin
      idle_pct = (n >= 80 && n < 130) ? 0 : 10;
      r = $urandom_range(99);
      if (r < 40) cmd = CMD_INSERT;
      else if (r < 65) cmd = CMD_REMOVE;
      else if (r < 95) cmd = CMD_READ;
      else cmd = 2'd3;
      if ($urandom_range(9) == 0) begin
        pos = $urandom();
        cnt = $urandom();
      end else begin
        pos = $urandom_range(model_len + 1);
        cnt = (cmd == CMD_READ) ? $urandom_range(70) : $urandom_range(12);
      end
      send_cmd(cmd, pos, cnt, $urandom(), $urandom(), $urandom_range(1));
      // keep the table from filling permanently
      if (model_len > 200) begin
        send_cmd(CMD_REMOVE, 0, model_len - 20, 0, 0, 0);
      end
    end
    idle_pct = 10;
    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
